// ===== hdl/brwlt_pkg.sv =====
// Shared types and constants for the block reader/writer lock table.
// No dependencies; imported by every module under hdl/.
package brwlt_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 48;
    localparam int COUNT_BITS    = 16;
    localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TOTAL_BITS    = COUNT_BITS + 4;
    // Writers: every slot plus the whole-file writer, plus headroom
    localparam int WCNT_BITS     = $clog2(TABLE_ENTRIES + 2);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
    localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(TABLE_ENTRIES - 1);

    // Request opcodes
    typedef enum logic [1:0] {
        OP_RD_LOCK   = 2'd0,
        OP_RD_UNLOCK = 2'd1,
        OP_WR_LOCK   = 2'd2,
        OP_WR_UNLOCK = 2'd3
    } op_t;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_WAIT     = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOT_HELD = 2'd3
    } status_t;

    // Slot read port, as seen by the controller
    typedef struct packed {
        logic                  valid;
        logic                  match;
        logic [COUNT_BITS-1:0] readers;
        logic                  writer;
    } slot_rd_t;

    // Slot write command from the controller
    typedef struct packed {
        logic                  en;
        logic [IDX_BITS-1:0]   idx;
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] readers;
        logic                  writer;
    } slot_upd_t;

endpackage

// ===== hdl/brwlt_slot_table.sv =====
// Slot storage for the lock table: valid bits, keys, reader counts, writer flags.
// Holds the shared key comparator. Depends on brwlt_pkg.
module brwlt_slot_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [brwlt_pkg::IDX_BITS-1:0]      rd_idx,
    input  logic [brwlt_pkg::KEY_BITS-1:0]      cmp_key,
    output brwlt_pkg::slot_rd_t                 rd,
    input  brwlt_pkg::slot_upd_t                upd
);
    import brwlt_pkg::*;

    logic [TABLE_ENTRIES-1:0] slot_valid_reg;
    logic [KEY_BITS-1:0]      slot_key_reg     [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]    slot_readers_reg [TABLE_ENTRIES];
    logic                     slot_writer_reg  [TABLE_ENTRIES];

    // Valid bits: cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
        end else if (upd.en) begin
            slot_valid_reg[upd.idx] <= upd.valid;
        end
    end

    // Slot payload: undefined until written
    always_ff @(posedge aclk) begin
        if (upd.en) begin
            slot_key_reg[upd.idx]     <= upd.key;
            slot_readers_reg[upd.idx] <= upd.readers;
            slot_writer_reg[upd.idx]  <= upd.writer;
        end
    end

    // Single read port and the shared key compare
    always_comb begin
        rd.valid   = slot_valid_reg[rd_idx];
        rd.match   = slot_valid_reg[rd_idx] && (slot_key_reg[rd_idx] == cmp_key);
        rd.readers = slot_readers_reg[rd_idx];
        rd.writer  = slot_writer_reg[rd_idx];
    end

endmodule

// ===== hdl/brwlt_ctrl.sv =====
// Sequencer for the lock table: slot scan, lock decision, counters, response register.
// Depends on brwlt_pkg; drives brwlt_slot_table through its read and update ports.
module brwlt_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        in_op,
    input  logic                              in_whole_file,
    input  logic [brwlt_pkg::KEY_BITS-1:0]    in_key,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_granted,
    output logic [1:0]                        out_status,
    output logic [brwlt_pkg::IDX_BITS-1:0]    rd_idx,
    output logic [brwlt_pkg::KEY_BITS-1:0]    cmp_key,
    input  brwlt_pkg::slot_rd_t               rd,
    output brwlt_pkg::slot_upd_t              upd
);
    import brwlt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_RESP   = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    op_t                   op_reg;
    logic                  whole_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic                  hit_reg;
    logic [IDX_BITS-1:0]   hit_idx_reg;
    logic                  free_ok_reg;
    logic [IDX_BITS-1:0]   free_idx_reg;
    logic [COUNT_BITS-1:0] file_readers_reg, file_readers_next;
    logic                  file_writer_reg, file_writer_next;
    logic [TOTAL_BITS-1:0] total_readers_reg, total_readers_next;
    logic [WCNT_BITS-1:0]  total_writers_reg, total_writers_next;
    status_t               status_reg, status_next;

    logic                  accept;
    logic [TOTAL_BITS-1:0] tr_inc, tr_dec;
    logic [WCNT_BITS-1:0]  tw_inc, tw_dec;
    logic [COUNT_BITS-1:0] rd_dec;

    assign accept      = in_valid && in_ready;
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_RESP);
    assign out_status  = status_reg;
    assign out_granted = (status_reg == ST_OK);

    // One slot read address: scan index while scanning, hit slot when deciding
    assign rd_idx  = (state_reg == S_SCAN) ? idx_reg : hit_idx_reg;
    assign cmp_key = key_reg;

    // Counter steps, totals saturate at zero on release
    assign tr_inc = total_readers_reg + TOTAL_BITS'(1);
    assign tr_dec = (total_readers_reg == '0) ? '0 : total_readers_reg - TOTAL_BITS'(1);
    assign tw_inc = total_writers_reg + WCNT_BITS'(1);
    assign tw_dec = (total_writers_reg == '0) ? '0 : total_writers_reg - WCNT_BITS'(1);
    assign rd_dec = rd.readers - COUNT_BITS'(1);

    // Lock decision, evaluated in the decide cycle
    always_comb begin
        status_next        = ST_OK;
        file_readers_next  = file_readers_reg;
        file_writer_next   = file_writer_reg;
        total_readers_next = total_readers_reg;
        total_writers_next = total_writers_reg;
        upd.en      = 1'b0;
        upd.idx     = hit_idx_reg;
        upd.valid   = 1'b1;
        upd.key     = key_reg;
        upd.readers = rd.readers;
        upd.writer  = rd.writer;

        if (whole_reg) begin
            unique case (op_reg)
                OP_RD_LOCK: begin
                    if (total_writers_reg != '0) begin
                        status_next = ST_WAIT;
                    end else if (file_readers_reg == COUNT_MAX ||
                                 total_readers_reg == TOTAL_MAX) begin
                        status_next = ST_FULL;
                    end else begin
                        file_readers_next  = file_readers_reg + COUNT_BITS'(1);
                        total_readers_next = tr_inc;
                    end
                end
                OP_RD_UNLOCK: begin
                    if (file_readers_reg == '0) begin
                        status_next = ST_NOT_HELD;
                    end else begin
                        file_readers_next  = file_readers_reg - COUNT_BITS'(1);
                        total_readers_next = tr_dec;
                    end
                end
                OP_WR_LOCK: begin
                    if (total_readers_reg != '0 || total_writers_reg != '0) begin
                        status_next = ST_WAIT;
                    end else begin
                        file_writer_next   = 1'b1;
                        total_writers_next = tw_inc;
                    end
                end
                OP_WR_UNLOCK: begin
                    if (!file_writer_reg) begin
                        status_next = ST_NOT_HELD;
                    end else begin
                        file_writer_next   = 1'b0;
                        total_writers_next = tw_dec;
                    end
                end
            endcase
        end else begin
            unique case (op_reg)
                OP_RD_LOCK: begin
                    if (file_writer_reg || (hit_reg && rd.writer)) begin
                        status_next = ST_WAIT;
                    end else if (!hit_reg) begin
                        if (!free_ok_reg || total_readers_reg == TOTAL_MAX) begin
                            status_next = ST_FULL;
                        end else begin
                            upd.en             = 1'b1;
                            upd.idx            = free_idx_reg;
                            upd.readers        = COUNT_BITS'(1);
                            upd.writer         = 1'b0;
                            total_readers_next = tr_inc;
                        end
                    end else if (rd.readers == COUNT_MAX ||
                                 total_readers_reg == TOTAL_MAX) begin
                        status_next = ST_FULL;
                    end else begin
                        upd.en             = 1'b1;
                        upd.readers        = rd.readers + COUNT_BITS'(1);
                        total_readers_next = tr_inc;
                    end
                end
                OP_RD_UNLOCK: begin
                    if (!hit_reg || rd.readers == '0) begin
                        status_next = ST_NOT_HELD;
                    end else begin
                        upd.en             = 1'b1;
                        upd.readers        = rd_dec;
                        upd.valid          = (rd_dec != '0) || rd.writer;
                        total_readers_next = tr_dec;
                    end
                end
                OP_WR_LOCK: begin
                    if (file_writer_reg || file_readers_reg != '0 || hit_reg) begin
                        status_next = ST_WAIT;
                    end else if (!free_ok_reg) begin
                        status_next = ST_FULL;
                    end else begin
                        upd.en             = 1'b1;
                        upd.idx            = free_idx_reg;
                        upd.readers        = '0;
                        upd.writer         = 1'b1;
                        total_writers_next = tw_inc;
                    end
                end
                OP_WR_UNLOCK: begin
                    if (!hit_reg || !rd.writer) begin
                        status_next = ST_NOT_HELD;
                    end else begin
                        upd.en             = 1'b1;
                        upd.writer         = 1'b0;
                        upd.valid          = (rd.readers != '0);
                        total_writers_next = tw_dec;
                    end
                end
            endcase
        end

        // Only the decide cycle commits
        if (state_reg != S_DECIDE) begin
            upd.en = 1'b0;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = in_whole_file ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and lock counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            file_readers_reg  <= '0;
            file_writer_reg   <= 1'b0;
            total_readers_reg <= '0;
            total_writers_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_DECIDE) begin
                file_readers_reg  <= file_readers_next;
                file_writer_reg   <= file_writer_next;
                total_readers_reg <= total_readers_next;
                total_writers_reg <= total_writers_next;
            end
        end
    end

    // Request capture, scan bookkeeping, response status
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg      <= op_t'(in_op);
            whole_reg   <= in_whole_file;
            key_reg     <= in_key;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            free_ok_reg <= 1'b0;
        end else if (state_reg == S_SCAN) begin
            idx_reg <= idx_reg + IDX_BITS'(1);
            if (rd.match) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= idx_reg;
            end
            if (!rd.valid && !free_ok_reg) begin
                free_ok_reg  <= 1'b1;
                free_idx_reg <= idx_reg;
            end
        end
        if (state_reg == S_DECIDE) begin
            status_reg <= status_next;
        end
    end

`ifndef SYNTHESIS
    // A whole-file writer excludes every other writer
    a_file_writer_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        file_writer_reg |-> total_writers_reg == WCNT_BITS'(1))
        else $error("whole-file writer coexists with other writers");

    // A whole-file writer excludes every reader
    a_file_writer_no_readers: assert property (@(posedge aclk) disable iff (!aresetn)
        file_writer_reg |-> total_readers_reg == '0)
        else $error("whole-file writer coexists with readers");

    // A granted write lock bumps the writer total by one
    a_write_grant_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECIDE && op_reg == OP_WR_LOCK && status_next == ST_OK)
        |=> total_writers_reg == $past(total_writers_reg) + WCNT_BITS'(1))
        else $error("write grant did not update writer total");

    // No new request taken while a response is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid))
        else $error("ready asserted with a pending response");
`endif

endmodule

// ===== hdl/block_reader_writer_lock_table_top.sv =====
// Sequence: a whole-file request passes from acceptance through the decide state to the
// response state; a block request first runs the slot scan over all TABLE_ENTRIES entries,
// which compares one table entry per cycle on the single key comparator, then decides.
// Only one transaction is in flight: a new request is accepted only after the response
// has been taken on m_ready.
// Reset: synchronous active-low aresetn clears slot valid bits, lock counters and the FSM.
module block_reader_writer_lock_table_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_op,
    input  logic                              s_whole_file,
    input  logic [brwlt_pkg::KEY_BITS-1:0]    s_block_position,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_granted,
    output logic [1:0]                        m_status
);
    import brwlt_pkg::*;

    logic [IDX_BITS-1:0] rd_idx;
    logic [KEY_BITS-1:0] cmp_key;
    slot_rd_t            slot_rd;
    slot_upd_t           slot_upd;

    // Slot storage and key comparator
    brwlt_slot_table u_slot_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (rd_idx),
        .cmp_key (cmp_key),
        .rd      (slot_rd),
        .upd     (slot_upd)
    );

    // Scan sequencer and lock decision
    brwlt_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_op         (s_op),
        .in_whole_file (s_whole_file),
        .in_key        (s_block_position),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_granted   (m_granted),
        .out_status    (m_status),
        .rd_idx        (rd_idx),
        .cmp_key       (cmp_key),
        .rd            (slot_rd),
        .upd           (slot_upd)
    );

endmodule
